// ===== rtl/sop_pkg.sv =====
// Shared types and constants for the sphere overlap push-out pipeline.
// Used by the sqrt cell, the divide cell and the top level; no dependencies.
package sop_pkg;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 33;

  // Everything one item carries down the pipeline.
  typedef struct packed {
    logic              hit;
    logic              push;
    logic [2:0]        neg;
    logic [2:0][31:0]  a;
    logic [2:0][31:0]  base;
    logic [2:0][32:0]  m;
    logic [31:0]       s;
    logic [2:0][65:0]  sq;
    logic [63:0]       s2;
    logic [63:0]       rad;
    logic [34:0]       srem;
    logic [31:0]       root;
    logic [2:0][32:0]  num;
    logic [2:0][31:0]  drem;
    logic [2:0][32:0]  quo;
  } item_t;

endpackage

// ===== rtl/sop_sqrt_cell.sv =====
// One cell of the square root chain: resolves one root bit per stage.
// Depends on sop_pkg.
module sop_sqrt_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vld_i,
  input  sop_pkg::item_t item_i,
  output logic          vld_o,
  output sop_pkg::item_t item_o
);
  import sop_pkg::*;

  logic [34:0] t;
  logic [34:0] trial;
  item_t       item_next;

  always_comb begin
    item_next = item_i;
    t         = {item_i.srem[32:0], item_i.rad[63:62]};
    trial     = {1'b0, item_i.root, 2'b01};
    item_next.rad = {item_i.rad[61:0], 2'b00};
    if (t >= trial) begin
      item_next.srem = t - trial;
      item_next.root = {item_i.root[30:0], 1'b1};
    end else begin
      item_next.srem = t;
      item_next.root = {item_i.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_o <= item_next;
    end
  end

endmodule

// ===== rtl/sop_div_cell.sv =====
// One cell of the divide chain: one quotient bit per stage for all three axes.
// Depends on sop_pkg.
module sop_div_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vld_i,
  input  sop_pkg::item_t item_i,
  output logic          vld_o,
  output sop_pkg::item_t item_o
);
  import sop_pkg::*;

  logic [2:0][32:0] t;
  item_t            item_next;

  always_comb begin
    item_next = item_i;
    for (int i = 0; i < 3; i++) begin
      t[i] = {item_i.drem[i], item_i.num[i][32]};
      item_next.num[i] = {item_i.num[i][31:0], 1'b0};
      if (t[i] >= {1'b0, item_i.root}) begin
        item_next.drem[i] = 32'(t[i] - {1'b0, item_i.root});
        item_next.quo[i]  = {item_i.quo[i][31:0], 1'b1};
      end else begin
        item_next.drem[i] = t[i][31:0];
        item_next.quo[i]  = {item_i.quo[i][31:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_o <= item_next;
    end
  end

endmodule

// ===== rtl/sphere_overlap_push_out_top.sv =====
// Sphere overlap test with push-out: one sphere pair may be transferred every cycle, and each
// result passes three front stages, 32 square root cells, one multiply stage, 33 divide cells
// and the output register. The whole pipeline advances together and halts only while a
// finished result waits at the output, so throughput is one pair per cycle whenever the
// result side keeps taking. Depends on sop_pkg and the two cells.
module sphere_overlap_push_out_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // a_x, a_y, a_z, radius_a, b_x, b_y, b_z, radius_b, zero padding
  input  logic [255:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_x, out_y, out_z
  output logic [95:0]  m_axis_tdata,
  // hit
  output logic         m_axis_tuser
);
  import sop_pkg::*;

  logic             en;
  logic [2:0][31:0] in_a;
  logic [2:0][31:0] in_b;
  logic [30:0]      rad_a;
  logic [30:0]      rad_b;

  logic             v1, v2, v3, vm;
  item_t            p1, p2, p3, pm;
  item_t            p1_next, p2_next, p3_next, pm_next;
  logic [66:0]      sum;

  logic [SQRT_STEPS:0] sv;
  item_t               sp [SQRT_STEPS+1];
  logic [DIV_STEPS:0]  dv;
  item_t               dp [DIV_STEPS+1];

  logic [2:0][31:0] res;
  logic [2:0][33:0] off;
  logic [2:0][34:0] tot;
  logic             hit_q;
  logic [2:0][31:0] res_q;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  assign in_a[0] = s_axis_tdata[31:0];
  assign in_a[1] = s_axis_tdata[63:32];
  assign in_a[2] = s_axis_tdata[95:64];
  assign rad_a   = s_axis_tdata[126:96];
  assign in_b[0] = s_axis_tdata[158:127];
  assign in_b[1] = s_axis_tdata[190:159];
  assign in_b[2] = s_axis_tdata[222:191];
  assign rad_b   = s_axis_tdata[253:223];

  // Differences, magnitudes and the radius sum.
  always_comb begin
    logic [32:0] d;
    p1_next   = '0;
    p1_next.s = {1'b0, rad_a} + {1'b0, rad_b};
    for (int i = 0; i < 3; i++) begin
      d = {in_b[i][31], in_b[i]} - {in_a[i][31], in_a[i]};
      p1_next.neg[i]  = d[32];
      p1_next.m[i]    = d[32] ? (33'd0 - d) : d;
      p1_next.a[i]    = in_a[i];
      p1_next.base[i] = in_b[i];
    end
  end

  always_comb begin
    p2_next    = p1;
    p2_next.s2 = 64'(p1.s * p1.s);
    for (int i = 0; i < 3; i++) begin
      p2_next.sq[i] = 66'(p1.m[i] * p1.m[i]);
    end
  end

  // The sum keeps its carries, so a huge separation is always a miss.
  assign sum = {1'b0, p2.sq[0]} + {1'b0, p2.sq[1]} + {1'b0, p2.sq[2]};

  always_comb begin
    p3_next      = p2;
    p3_next.hit  = (sum <= {3'b000, p2.s2});
    p3_next.push = p3_next.hit && (sum != '0);
    p3_next.base = p3_next.hit ? p2.a : p2.base;
    p3_next.rad  = sum[63:0];
    p3_next.srem = '0;
    p3_next.root = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= p1_next;
      p2 <= p2_next;
      p3 <= p3_next;
    end
  end

  assign sv[0] = v3;
  assign sp[0] = p3;

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    sop_sqrt_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .vld_i  (sv[g]),
      .item_i (sp[g]),
      .vld_o  (sv[g+1]),
      .item_o (sp[g+1])
    );
  end

  // Scaled numerators with the rounding half of the length added in.
  always_comb begin
    logic [64:0] n;
    pm_next = sp[SQRT_STEPS];
    for (int i = 0; i < 3; i++) begin
      n = 65'(sp[SQRT_STEPS].s * sp[SQRT_STEPS].m[i])
          + {34'd0, sp[SQRT_STEPS].root[31:1]};
      pm_next.drem[i] = n[64:33];
      pm_next.num[i]  = n[32:0];
      pm_next.quo[i]  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (en) begin
      vm <= sv[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pm <= pm_next;
    end
  end

  assign dv[0] = vm;
  assign dp[0] = pm;

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    sop_div_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .vld_i  (dv[g]),
      .item_i (dp[g]),
      .vld_o  (dv[g+1]),
      .item_o (dp[g+1])
    );
  end

  // Apply the signed offset and saturate, or pass the base position through when there is no push.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      off[i] = dp[DIV_STEPS].neg[i] ? (34'd0 - {1'b0, dp[DIV_STEPS].quo[i]})
                                     : {1'b0, dp[DIV_STEPS].quo[i]};
      tot[i] = {{3{dp[DIV_STEPS].a[i][31]}}, dp[DIV_STEPS].a[i]}
               + {off[i][33], off[i]};
      if (!dp[DIV_STEPS].push) begin
        res[i] = dp[DIV_STEPS].base[i];
      end else if (!tot[i][34] && (tot[i][33:31] != 3'b000)) begin
        res[i] = 32'h7FFF_FFFF;
      end else if (tot[i][34] && (tot[i][33:31] != 3'b111)) begin
        res[i] = 32'h8000_0000;
      end else begin
        res[i] = tot[i][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= dv[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_q <= dp[DIV_STEPS].hit;
      res_q <= res;
    end
  end

  assign m_axis_tdata = {res_q[2], res_q[1], res_q[0]};
  assign m_axis_tuser = hit_q;

  a_ready_rule : assert property (@(posedge clk)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow the output stall");

  a_reset_empty : assert property (@(posedge clk)
    rst |=> (!m_axis_tvalid && !v1 && !vm))
    else $error("pipeline not empty after reset");

  a_stall_holds : assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |=> ($stable(v1) && $stable(vm) && $stable(dv)))
    else $error("pipeline moved during a stall");

endmodule

// ===== tb/sv/tb_sphere_overlap_push_out_top.sv =====
// Testbench for the sphere overlap push-out pipeline: directed and random sphere pairs,
// checked against an in-bench predictor. Depends only on sphere_overlap_push_out_top.
`timescale 1ns / 100ps

module tb_sphere_overlap_push_out_top;

  // Declared from the highest bits down, so a_x lands in the lowest bits.
  typedef struct packed {
    logic [30:0] radius_b;
    logic [31:0] b_z, b_y, b_x;
    logic [30:0] radius_a;
    logic [31:0] a_z, a_y, a_x;
  } pair_t;

  typedef struct packed {
    logic [31:0] out_z, out_y, out_x;
    logic        hit;
  } touch_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [255:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;
  logic         m_axis_tuser;

  pair_t  pending_pairs[$];
  touch_t expected_touch[$];
  int     errors = 0;
  int     results_seen = 0;
  int     hits_seen = 0;
  bit     stimulus_done = 1'b0;
  bit     hold_sink = 1'b0;
  bit     in_taken = 1'b0;
  bit     out_taken = 1'b0;
  int     send_gap = 0;
  int     take_gap = 0;
  int     send_draw = 0;
  int     take_draw = 0;

  sphere_overlap_push_out_top dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [127:0] isqrt128(logic [127:0] n);
    logic [127:0] res;
    logic [127:0] bitv;
    res = 0;
    bitv = 128'd1 << 126;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] clamp32(logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'h7fffffff;
    if (v < -128'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // Push-out of B along the line of centres, rounded half away from zero.
  function automatic touch_t push_out(pair_t p);
    touch_t r;
    logic signed [127:0] a[3], d[3];
    logic [127:0] m[3], sum, s, s2, len, q;
    a[0] = 128'(signed'(p.a_x)); a[1] = 128'(signed'(p.a_y)); a[2] = 128'(signed'(p.a_z));
    d[0] = 128'(signed'(p.b_x)) - a[0];
    d[1] = 128'(signed'(p.b_y)) - a[1];
    d[2] = 128'(signed'(p.b_z)) - a[2];
    s = 128'(p.radius_a) + 128'(p.radius_b);
    s2 = s * s;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = d[i] < 0 ? 128'(-d[i]) : 128'(d[i]);
      sum = sum + m[i] * m[i];
    end
    if (sum > s2) begin
      r.hit = 1'b0;
      r.out_x = p.b_x; r.out_y = p.b_y; r.out_z = p.b_z;
    end else if (sum == 0) begin
      r.hit = 1'b1;
      r.out_x = p.a_x; r.out_y = p.a_y; r.out_z = p.a_z;
    end else begin
      logic [31:0] o[3];
      r.hit = 1'b1;
      len = isqrt128(sum);
      for (int i = 0; i < 3; i++) begin
        q = (s * m[i] + (len >> 1)) / len;
        o[i] = clamp32(a[i] + (d[i] < 0 ? -signed'(q) : signed'(q)));
      end
      r.out_x = o[0]; r.out_y = o[1]; r.out_z = o[2];
    end
    return r;
  endfunction

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($urandom_range(0, 2000)) - 32'd1000;
      default: return 32'($urandom_range(0, 32'h00ffffff)) - 32'h00800000;
    endcase
  endfunction

  // A pair that mostly overlaps, with A and B near each other.
  function automatic pair_t near_pair();
    pair_t p;
    int mode;
    mode = $urandom_range(0, 2);
    p.a_x = rand_coord(mode); p.a_y = rand_coord(mode); p.a_z = rand_coord(mode);
    p.b_x = p.a_x + rand_coord(mode == 0 ? 2 : mode);
    p.b_y = p.a_y + rand_coord(mode == 0 ? 2 : mode);
    p.b_z = p.a_z + rand_coord(mode == 0 ? 2 : mode);
    p.radius_a = $urandom_range(0, 3) == 0 ? 31'($urandom()) : 31'($urandom_range(0, 32'h00ffffff));
    p.radius_b = $urandom_range(0, 3) == 0 ? 31'($urandom()) : 31'($urandom_range(0, 32'h00ffffff));
    return p;
  endfunction

  // Transfers on both sides are recorded at the rising edge.
  always @(posedge clk) begin
    if (rst) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken  <= s_axis_tvalid && s_axis_tready;
      out_taken <= m_axis_tvalid && m_axis_tready;
    end
  end

  // Driver: presents one pair per transfer with a random gap before each.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        expected_touch.push_back(push_out(pair_t'(s_axis_tdata[253:0])));
        void'(pending_pairs.pop_front());
        send_draw = $urandom_range(0, 3) == 0 ? $urandom_range(0, 12) : 0;
        if (send_draw == 0 && pending_pairs.size() > 0) begin
          s_axis_tdata <= {2'd0, pending_pairs[0]};
        end else begin
          send_gap <= send_draw;
          s_axis_tvalid <= 1'b0;
        end
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
      end else if (!s_axis_tvalid && pending_pairs.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'd0, pending_pairs[0]};
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      touch_t got, want;
      got = touch_t'({m_axis_tdata, m_axis_tuser});
      results_seen++;
      if (got.hit) hits_seen++;
      if (expected_touch.size() == 0) begin
        $error("result with nothing expected: %h", got);
        errors++;
      end else begin
        want = expected_touch.pop_front();
        if (got.hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, got.hit); errors++;
        end
        if (got.out_x !== want.out_x) begin
          $error("out_x: expected %h, got %h", want.out_x, got.out_x); errors++;
        end
        if (got.out_y !== want.out_y) begin
          $error("out_y: expected %h, got %h", want.out_y, got.out_y); errors++;
        end
        if (got.out_z !== want.out_z) begin
          $error("out_z: expected %h, got %h", want.out_z, got.out_z); errors++;
        end
      end
    end
  end

  // Receiver: random stalls per result, plus one long hold-off.
  always @(negedge clk) begin
    if (rst || hold_sink) begin
      m_axis_tready <= 1'b0;
    end else if (out_taken) begin
      take_draw = $urandom_range(0, 3) == 0 ? $urandom_range(0, 12) : 0;
      if (take_draw > 0) begin
        take_gap <= take_draw;
        m_axis_tready <= 1'b0;
      end
    end else if (take_gap > 0) begin
      take_gap <= take_gap - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    repeat (300) @(posedge clk);
    hold_sink = 1'b1;
    repeat (400) @(posedge clk);
    hold_sink = 1'b0;
  end

  initial begin
    pair_t p;
    logic [31:0] ext[4];
    ext = '{32'h80000000, 32'h7fffffff, 32'h0, 32'hffffffff};
    // Coincident centres, zero radii.
    p = '0; pending_pairs.push_back(p);
    // Touching exactly along x: distance 3.0, radii 1.0 and 2.0.
    p = '0; p.b_x = 32'h00030000; p.radius_a = 31'h10000; p.radius_b = 31'h20000;
    pending_pairs.push_back(p);
    // Just apart.
    p.b_x = 32'h00030001; pending_pairs.push_back(p);
    // Huge separations on every axis.
    p = '0; p.a_x = ext[0]; p.a_y = ext[0]; p.a_z = ext[0];
    p.b_x = ext[1]; p.b_y = ext[1]; p.b_z = ext[1];
    p.radius_a = '1; p.radius_b = '1; pending_pairs.push_back(p);
    // Extreme centres, first with maximum radii (hits that saturate), then with zero radii (misses).
    for (int i = 0; i < 4; i++) begin
      p.a_x = ext[i]; p.a_y = ext[(i + 1) % 4]; p.a_z = ext[(i + 2) % 4];
      p.b_x = ext[3 - i]; p.b_y = ext[(i + 3) % 4]; p.b_z = ext[i];
      p.radius_a = '1; p.radius_b = '1;
      pending_pairs.push_back(p);
      p.radius_a = '0; p.radius_b = '0;
      pending_pairs.push_back(p);
    end
    // Coincident centres with non-zero radii, at an extreme.
    p = '0; p.a_x = ext[0]; p.b_x = ext[0]; p.radius_a = 31'h1234;
    pending_pairs.push_back(p);
    // Push out to the far corners so the sum saturates high and low.
    p = '0; p.a_x = 32'h7fff0000; p.b_x = 32'h7fff8000; p.radius_b = 31'h7fff0000;
    pending_pairs.push_back(p);
    p.a_x = 32'h80010000; p.b_x = 32'h80008000; pending_pairs.push_back(p);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    for (int n = 0; n < 1900; n++) begin
      if ($urandom_range(0, 4) == 0) begin
        p = pair_t'(254'({$urandom(), $urandom(), $urandom(), $urandom(),
                          $urandom(), $urandom(), $urandom(), $urandom()}));
      end else begin
        p = near_pair();
      end
      pending_pairs.push_back(p);
    end
    stimulus_done = 1'b1;
  end

  initial begin
    wait (stimulus_done);
    wait (pending_pairs.size() == 0 && !s_axis_tvalid);
    wait (expected_touch.size() == 0);
    repeat (100) @(posedge clk);
    $display("Checked %0d sphere pairs, %0d of them overlapping, with stalls on both sides.",
             results_seen, hits_seen);
    if (errors == 0 && expected_touch.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
